@@ src/swmd_pkg.sv @@
// shared constants, types and state codes for the sliding window mean/deviation block
// no dependencies; every other file but swmd_ram imports this package
package swmd_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int SAMPLE_W   = 16;
  localparam int DEV_W      = 16;
  localparam int SUM_W      = 27;
  localparam int SQ_W       = 32;
  localparam int SQSUM_W    = 42;
  localparam int CNT_W      = 11;
  localparam int WLEN_W     = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // shift-subtract unit
  localparam int ITER_W = SQSUM_W;
  localparam int REM_W  = 20;
  localparam int STEP_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_EVENT_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(1);
  localparam logic [WLEN_W-1:0]    WLEN_RESET        = WLEN_W'(256);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DIV1_GO,
    S_DIV1,
    S_MUL,
    S_ACC,
    S_DIV2_GO,
    S_DIV2,
    S_SQRT_GO,
    S_SQRT,
    S_DONE
  } swmd_state_t;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } iter_op_t;

  typedef struct packed {
    logic              start;
    iter_op_t          op;
    logic [STEP_W-1:0] steps;
  } iter_cmd_t;

endpackage

@@ src/swmd_if.sv @@
// handshake channels: input sample word, result word and register write port
// depends on swmd_pkg for field widths
interface swmd_in_if;
  import swmd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       sample_valid;

  modport source (output valid, output sample, output sample_valid, input ready);
  modport sink   (input valid, input sample, input sample_valid, output ready);
endinterface

interface swmd_out_if;
  import swmd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] window_mean;
  logic        [DEV_W-1:0]    window_deviation;
  logic                       counted;

  modport source (output valid, output window_mean, output window_deviation,
                  output counted, input ready);
  modport sink   (input valid, input window_mean, input window_deviation,
                  input counted, output ready);
endinterface

interface swmd_cfg_if;
  import swmd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/swmd_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
module swmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/swmd_iter.sv @@
// shared shift-subtract unit: restoring division or digit-by-digit square root
// operand is left aligned; one quotient or root bit per cycle; depends on swmd_pkg
module swmd_iter (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swmd_pkg::iter_cmd_t    cmd,
  input  logic [swmd_pkg::ITER_W-1:0] operand,
  input  logic [swmd_pkg::CNT_W-1:0]  divisor,
  output logic                   done,
  output logic [swmd_pkg::ITER_W-1:0] result
);
  import swmd_pkg::*;

  logic              busy_r;
  logic [STEP_W-1:0] cnt_r;
  logic              done_r;
  iter_op_t          op_r;
  logic [ITER_W-1:0] num_r;
  logic [REM_W-1:0]  rem_r;
  logic [ITER_W-1:0] q_r;
  logic [CNT_W-1:0]  div_r;

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] trial;
  logic             ge;

  always_comb begin
    if (op_r == OP_SQRT) begin
      shifted = {rem_r[REM_W-3:0], num_r[ITER_W-1 -: 2]};
      trial   = {q_r[REM_W-3:0], 2'b01};
    end else begin
      shifted = {rem_r[REM_W-2:0], num_r[ITER_W-1]};
      trial   = REM_W'(div_r);
    end
    ge = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == STEP_W'(1));
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.op;
      num_r <= operand;
      div_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (shifted - trial) : shifted;
      q_r   <= {q_r[ITER_W-2:0], ge};
      num_r <= (op_r == OP_SQRT) ? (num_r << 2) : (num_r << 1);
    end
  end

  assign done   = done_r;
  assign result = q_r;

endmodule

@@ src/sliding_window_mean_deviation.sv @@
// sliding window mean and deviation over signed q8.8 samples
// depends on swmd_pkg, swmd_if, swmd_ram and swmd_iter
//
// in_if takes one word per sample (sample, sample_valid); out_if gives one word per
// input word: window_mean, window_deviation and counted. cfg_if writes register 0
// (event_mode) or 1 (window_length); either write clears sums, fill count, ring
// pointer and held statistics, ring contents are kept; other indexes are ignored.
// cfg_if is always ready; write it only while idle, the block does not check it.
// A counted sample runs through the shared shift-subtract unit three times:
// mean division (27 steps), mean-square division (42 steps) and square root
// (16 steps), plus the sequencing states and done flags around them.
// A word that is not counted goes straight from idle to the final state.
// in_if is not ready while a word is in work. The result sits in an output
// register, so the next word is taken while an earlier result waits; a result
// that cannot be loaded because the receiver stalls holds the block in its
// final state until out_if.ready.
// Reset: event_mode 0, window_length 256, statistics zero; no clearing pass.
module sliding_window_mean_deviation (
  input  logic       clk,
  input  logic       rst_n,
  swmd_in_if.sink    in_if,
  swmd_out_if.source out_if,
  swmd_cfg_if.sink   cfg_if
);
  import swmd_pkg::*;

  swmd_state_t state_r, state_nxt;

  logic                       event_mode_r;
  logic [WLEN_W-1:0]          window_length_r;
  logic signed [SUM_W-1:0]    sample_sum_r;
  logic [SQSUM_W-1:0]         square_sum_r;
  logic [CNT_W-1:0]           fill_count_r;
  logic [RING_AW-1:0]         wi_r;
  logic                       prev_valid_r;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic [DEV_W-1:0]           dev_r;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       remove_r;
  logic                       counted_r;
  logic [SQ_W-1:0]            sq_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_mean_r;
  logic [DEV_W-1:0]           out_dev_r;
  logic                       out_counted_r;

  logic                       accept;
  logic                       count_it;
  logic                       load_out;
  logic                       cfg_clear;
  logic [CNT_W-1:0]           len_eff;
  logic                       remove;
  logic [17:0]                wi_x, len_x, oldest_x;
  logic [SAMPLE_W+SQ_W-1:0]   ram_rdata;
  logic signed [SAMPLE_W-1:0] old_s;
  logic [SQ_W-1:0]            old_sq;
  logic [SUM_W-1:0]           sum_mag;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          adiff;
  logic [ITER_W-1:0]          iter_operand;
  logic [ITER_W-1:0]          iter_result;
  logic                       iter_done;
  iter_cmd_t                  cmd;

  // window length clamped to 1 .. ring depth - 1
  always_comb begin
    if (window_length_r == '0) begin
      len_eff = CNT_W'(1);
    end else if (17'(window_length_r) > 17'(RING_DEPTH - 1)) begin
      len_eff = CNT_W'(RING_DEPTH - 1);
    end else begin
      len_eff = CNT_W'(window_length_r);
    end
  end

  assign count_it = in_if.sample_valid && (!event_mode_r || !prev_valid_r);
  assign remove   = (fill_count_r >= len_eff);
  assign accept   = in_if.valid && in_if.ready;

  // oldest entry of the window, read ahead at accept
  always_comb begin
    wi_x  = 18'(wi_r);
    len_x = 18'(len_eff);
    if (wi_x >= len_x) begin
      oldest_x = wi_x - len_x;
    end else begin
      oldest_x = wi_x + 18'(RING_DEPTH) - len_x;
    end
  end

  swmd_ram #(
    .WIDTH (SAMPLE_W + SQ_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == S_ACC),
    .waddr (wi_r),
    .wdata ({sample_r, sq_r}),
    .raddr (oldest_x[RING_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign old_s  = ram_rdata[SAMPLE_W+SQ_W-1:SQ_W];
  assign old_sq = ram_rdata[SQ_W-1:0];

  assign sum_mag = sample_sum_r[SUM_W-1] ? SUM_W'(-sample_sum_r) : SUM_W'(sample_sum_r);
  assign diff    = (SAMPLE_W+1)'(sample_r) - (SAMPLE_W+1)'(mean_r);
  assign adiff   = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);

  swmd_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .operand (iter_operand),
    .divisor (fill_count_r),
    .done    (iter_done),
    .result  (iter_result)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd.start    = 1'b0;
    cmd.op       = OP_DIV;
    cmd.steps    = '0;
    iter_operand = '0;
    in_if.ready  = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_nxt = count_it ? S_SUM : S_DONE;
        end
      end
      S_SUM:     state_nxt = S_DIV1_GO;
      S_DIV1_GO: begin
        cmd.start    = 1'b1;
        cmd.op       = OP_DIV;
        cmd.steps    = STEP_W'(SUM_W);
        iter_operand = {sum_mag, (ITER_W-SUM_W)'(0)};
        state_nxt    = S_DIV1;
      end
      S_DIV1: begin
        if (iter_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:     state_nxt = S_ACC;
      S_ACC:     state_nxt = S_DIV2_GO;
      S_DIV2_GO: begin
        cmd.start    = 1'b1;
        cmd.op       = OP_DIV;
        cmd.steps    = STEP_W'(SQSUM_W);
        iter_operand = ITER_W'(square_sum_r);
        state_nxt    = S_DIV2;
      end
      S_DIV2: begin
        if (iter_done) begin
          state_nxt = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        // mean square fits 32 bits, root in 16 steps
        cmd.start    = 1'b1;
        cmd.op       = OP_SQRT;
        cmd.steps    = STEP_W'(SQ_W / 2);
        iter_operand = {iter_result[SQ_W-1:0], (ITER_W-SQ_W)'(0)};
        state_nxt    = S_SQRT;
      end
      S_SQRT: begin
        if (iter_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cfg_if.ready = 1'b1;
  assign cfg_clear    = cfg_if.valid &&
                        (cfg_if.index == REG_EVENT_MODE || cfg_if.index == REG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      event_mode_r    <= 1'b0;
      window_length_r <= WLEN_RESET;
      sample_sum_r    <= '0;
      square_sum_r    <= '0;
      fill_count_r    <= '0;
      wi_r            <= '0;
      prev_valid_r    <= 1'b0;
      mean_r          <= '0;
      dev_r           <= '0;
    end else if (cfg_clear) begin
      if (cfg_if.index == REG_EVENT_MODE) begin
        event_mode_r <= cfg_if.data[0];
      end else begin
        window_length_r <= cfg_if.data[WLEN_W-1:0];
      end
      sample_sum_r <= '0;
      square_sum_r <= '0;
      fill_count_r <= '0;
      wi_r         <= '0;
      prev_valid_r <= 1'b0;
      mean_r       <= '0;
      dev_r        <= '0;
    end else begin
      if (accept) begin
        prev_valid_r <= in_if.sample_valid;
      end
      case (state_r)
        S_SUM: begin
          if (remove_r) begin
            sample_sum_r <= sample_sum_r + SUM_W'(sample_r) - SUM_W'(old_s);
            square_sum_r <= square_sum_r - SQSUM_W'(old_sq);
          end else begin
            sample_sum_r <= sample_sum_r + SUM_W'(sample_r);
            fill_count_r <= fill_count_r + CNT_W'(1);
          end
        end
        S_DIV1: begin
          if (iter_done) begin
            mean_r <= sample_sum_r[SUM_W-1] ? SAMPLE_W'(-iter_result[SAMPLE_W-1:0])
                                            : SAMPLE_W'(iter_result[SAMPLE_W-1:0]);
          end
        end
        S_ACC: begin
          square_sum_r <= square_sum_r + SQSUM_W'(sq_r);
          wi_r <= (wi_r == RING_AW'(RING_DEPTH - 1)) ? '0 : wi_r + RING_AW'(1);
        end
        S_SQRT: begin
          if (iter_done) begin
            dev_r <= iter_result[DEV_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // item payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r  <= in_if.sample;
      remove_r  <= remove;
      counted_r <= count_it;
    end
    if (state_r == S_MUL) begin
      sq_r <= adiff[SAMPLE_W-1:0] * adiff[SAMPLE_W-1:0];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mean_r    <= mean_r;
      out_dev_r     <= dev_r;
      out_counted_r <= counted_r;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.window_mean      = out_mean_r;
  assign out_if.window_deviation = out_dev_r;
  assign out_if.counted          = out_counted_r;

endmodule

@@ tb/sliding_window_mean_deviation_tb.sv @@
`timescale 1ns / 100ps
// testbench for sliding_window_mean_deviation: directed and random sample words with
// random idling, checked word by word against an in-bench predictor of the statistics
// depends on swmd_pkg and the channel interfaces in swmd_if
module sliding_window_mean_deviation_tb;
  import swmd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic signed [SAMPLE_W-1:0] mean;
    logic        [DEV_W-1:0]    dev;
    logic                       counted;
  } stats_word_t;

  // predicts mean and deviation per word and holds the words still owed by the block
  class window_stats_board;
    logic signed [SAMPLE_W-1:0] sample_hist [RING_DEPTH];
    logic        [SQ_W-1:0]     square_hist [RING_DEPTH];
    longint                     sum_samples;
    longint unsigned            sum_squares;
    int unsigned                fill;
    int unsigned                wr_ptr;
    logic                       last_valid;
    logic signed [SAMPLE_W-1:0] held_mean;
    logic        [DEV_W-1:0]    held_dev;
    logic                       event_mode;
    logic        [WLEN_W-1:0]   window_len;
    stats_word_t                expected_stats[$];
    int                         errors;

    function new();
      event_mode = 1'b0;
      window_len = WLEN_RESET;
      errors     = 0;
      clear();
    endfunction

    function void clear();
      sum_samples = 0;
      sum_squares = 0;
      fill        = 0;
      wr_ptr      = 0;
      last_valid  = 1'b0;
      held_mean   = '0;
      held_dev    = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_EVENT_MODE) begin
        event_mode = data[0];
        clear();
      end else if (idx == REG_WINDOW_LENGTH) begin
        window_len = data[WLEN_W-1:0];
        clear();
      end
    endfunction

    function void note_word(logic signed [SAMPLE_W-1:0] smp, logic smp_valid);
      logic            take;
      int unsigned     len;
      int unsigned     oldest;
      longint          diff;
      longint unsigned sq;
      longint unsigned msq;
      longint unsigned root;
      longint unsigned trial;
      stats_word_t     w;
      take = smp_valid && !(event_mode && last_valid);
      if (take) begin
        len = (window_len == 0) ? 1 : window_len;
        if (fill >= len) begin
          // drop the entry that leaves the window, wrapping round the ring
          oldest = (wr_ptr >= len) ? wr_ptr - len : wr_ptr + RING_DEPTH - len;
          sum_samples -= longint'(sample_hist[oldest]);
          sum_squares -= square_hist[oldest];
        end else begin
          fill++;
        end
        sample_hist[wr_ptr] = smp;
        sum_samples += longint'(smp);
        held_mean = SAMPLE_W'(sum_samples / longint'(fill));
        diff = longint'(smp) - longint'(held_mean);
        sq = (diff < 0) ? -diff : diff;
        sq = sq * sq;
        square_hist[wr_ptr] = SQ_W'(sq);
        sum_squares += sq;
        msq = sum_squares / fill;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= msq) root = trial;
        end
        held_dev = DEV_W'(root);
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      end
      last_valid = smp_valid;
      w.mean    = held_mean;
      w.dev     = held_dev;
      w.counted = take;
      expected_stats.push_back(w);
    endfunction

    function void check_word(logic signed [SAMPLE_W-1:0] got_mean,
                             logic [DEV_W-1:0] got_dev, logic got_counted);
      stats_word_t w;
      if (expected_stats.size() == 0) begin
        $error("result word with nothing expected: mean %0d deviation %0d counted %0b",
               got_mean, got_dev, got_counted);
        errors++;
        return;
      end
      w = expected_stats.pop_front();
      if (got_mean !== w.mean) begin
        $error("window_mean: expected %0d, got %0d", w.mean, got_mean);
        errors++;
      end
      if (got_dev !== w.dev) begin
        $error("window_deviation: expected %0d, got %0d", w.dev, got_dev);
        errors++;
      end
      if (got_counted !== w.counted) begin
        $error("counted: expected %0b, got %0b", w.counted, got_counted);
        errors++;
      end
    endfunction

    function void leftover();
      if (expected_stats.size() != 0) begin
        $error("%0d result words never arrived", expected_stats.size());
        errors += expected_stats.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   quiet_cycles = 0;
  bit   hold_req;
  bit   no_idle;
  window_stats_board board;

  swmd_in_if  in_ch();
  swmd_out_if out_ch();
  swmd_cfg_if cfg_ch();

  sliding_window_mean_deviation i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short pauses, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int centre);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      1, 2, 3, 4: return SAMPLE_W'($urandom);
      default:    return SAMPLE_W'(centre + int'($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        board.check_word(out_ch.window_mean, out_ch.window_deviation, out_ch.counted);
      if (in_ch.valid && in_ch.ready)
        board.note_word(in_ch.sample, in_ch.sample_valid);
      if (cfg_ch.valid && cfg_ch.ready)
        board.set_register(cfg_ch.index, cfg_ch.data);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $error("no word moved for %0d cycles", STALL_LIMIT);
    $display("** sliding_window_mean_deviation: FAILED **");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_idle || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  task automatic send_word(logic signed [SAMPLE_W-1:0] smp, logic smp_valid);
    int gap;
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= smp;
    in_ch.sample_valid <= smp_valid;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    // let the word taken at this edge reach the board first
    @(posedge clk);
    while (board.expected_stats.size() != 0) @(posedge clk);
    // a non-counted word may still be finishing
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic setup_phase(logic mode_bit, logic [WLEN_W-1:0] len, bit poke_unused);
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    data    = CFG_DATA_W'($urandom);
    data[0] = mode_bit;
    write_reg(REG_EVENT_MODE, data);
    data = CFG_DATA_W'($urandom);
    data[WLEN_W-1:0] = len;
    write_reg(REG_WINDOW_LENGTH, data);
    // a write outside the register list must leave everything alone
    if (poke_unused) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int                centre;
    int                n_items;
    int                permille;
    logic              mode_bit;
    logic [WLEN_W-1:0] len;
    board    = new();
    hold_req = 1'b0;
    no_idle  = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.sample       <= '0;
    in_ch.sample_valid <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: sample mode, window of 256
    send_word(16'sh7FFF, 1'b1);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh0000, 1'b1);
    send_word(16'sh1234, 1'b0);
    send_word(16'shFFFF, 1'b1);
    send_word(16'shFFFF, 1'b0);
    send_word(16'sh0100, 1'b1);

    // edge counting with a window of two
    setup_phase(1'b1, WLEN_W'(2), 1'b1);
    send_word(16'sh0100, 1'b1);
    send_word(16'sh0200, 1'b1);
    send_word(16'sh7FFF, 1'b0);
    send_word(-16'sh0300, 1'b1);
    send_word(16'sh0000, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7FFF, 1'b1);

    // zero length behaves as one
    setup_phase(1'b0, WLEN_W'(0), 1'b0);
    send_word(16'sh0005, 1'b1);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh7FFF, 1'b1);

    for (int p = 0; p < 9; p++) begin
      mode_bit = $urandom_range(0, 1);
      len = ($urandom_range(0, 9) < 7) ? WLEN_W'($urandom_range(1, 32))
                                       : WLEN_W'($urandom_range(1, 1023));
      n_items = 35;
      case (p)
        0: begin mode_bit = 1'b0; len = WLEN_W'(1); n_items = 40; end
        1: begin mode_bit = 1'b1; len = WLEN_W'(3); n_items = 60; end
        2: begin mode_bit = 1'b0; len = '1; n_items = 60; end
        3: begin mode_bit = 1'b1; len = '0; n_items = 30; end
        // long run with a short sliding window
        4: begin mode_bit = 1'b0; len = WLEN_W'($urandom_range(2, 16)); n_items = 500; end
        8: begin mode_bit = 1'b1; len = '1; n_items = 40; end
        default: ;
      endcase
      setup_phase(mode_bit, len, p == 5);
      permille = mode_bit ? 500 : ((p == 4) ? 998 : 800);
      centre   = int'($urandom_range(0, 60000)) - 30000;
      if (p == 1) hold_req = 1'b1;
      if (p == 2) no_idle = 1'b1;
      for (int i = 0; i < n_items; i++)
        send_word(pick_sample(centre), $urandom_range(0, 999) < permille);
      no_idle = 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.leftover();
    if (board.errors == 0) begin
      $display("** sliding_window_mean_deviation: PASSED **");
    end else begin
      $display("** sliding_window_mean_deviation: FAILED **");
    end
    $finish;
  end

endmodule
